### design/pma_pkg.sv
// Package for the power meter averager: widths, window length, reciprocal
// constants for the fixed divisions, the sample and mode types.
// Depends on nothing; used by every module of the block.
package pma_pkg;

   localparam int WINDOW_LEN = 20;
   localparam int WIN_W      = $clog2(WINDOW_LEN);

   localparam int SENSE_W = 24;
   localparam int VOLT_W  = 20;
   localparam int HOLD_W  = 8;
   localparam int MODE_W  = 2;
   localparam int CORR_W  = 25;
   localparam int CUR_W   = 15;
   localparam int OVOLT_W = 16;
   localparam int PWR_W   = 17;

   localparam int SSUM_W = SENSE_W + WIN_W;
   localparam int VSUM_W = VOLT_W + WIN_W;

   localparam int STAGES = 9;

   localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd80;

   // Window sum of the sense samples divided by the window length.
   localparam int AS_N   = SSUM_W;
   localparam int AS_SH  = AS_N + WIN_W;
   localparam int AS_P_W = 2 * AS_N + 1;
   localparam int AS_Q_W = AS_N + 1 - WIN_W;
   localparam logic [AS_N:0] AS_MUL = (AS_N + 1)'(((64'd1 << AS_SH)
      + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

   // Window sum of the source samples divided by ten times the window length.
   localparam int AV_DIV = WINDOW_LEN * 10;
   localparam int AV_N   = VSUM_W;
   localparam int AV_L   = $clog2(AV_DIV);
   localparam int AV_SH  = AV_N + AV_L;
   localparam int AV_P_W = 2 * AV_N + 1;
   localparam int AV_Q_W = AV_N + 1 - AV_L;
   localparam logic [AV_N:0] AV_MUL = (AV_N + 1)'(((64'd1 << AV_SH)
      + 64'(AV_DIV) - 64'd1) / 64'(AV_DIV));

   // Source sample divided by ten.
   localparam int IV_DIV = 10;
   localparam int IV_N   = VOLT_W;
   localparam int IV_L   = $clog2(IV_DIV);
   localparam int IV_SH  = IV_N + IV_L;
   localparam int IV_P_W = 2 * IV_N + 1;
   localparam int IV_Q_W = IV_N + 1 - IV_L;
   localparam logic [IV_N:0] IV_MUL = (IV_N + 1)'(((64'd1 << IV_SH)
      + 64'(IV_DIV) - 64'd1) / 64'(IV_DIV));

   // Magnitude of a corrected sense value divided by 2000.
   localparam int CD_DIV = 2000;
   localparam int CD_N   = CORR_W;
   localparam int CD_L   = $clog2(CD_DIV);
   localparam int CD_SH  = CD_N + CD_L;
   localparam int CD_P_W = 2 * CD_N + 1;
   localparam int CD_Q_W = CD_N + 1 - CD_L;
   localparam logic [CD_N:0] CD_MUL = (CD_N + 1)'(((64'd1 << CD_SH)
      + 64'(CD_DIV) - 64'd1) / 64'(CD_DIV));

   // Magnitude of current times voltage divided by 10000.
   localparam int PP_W   = CUR_W + OVOLT_W + 1;
   localparam int PD_DIV = 10000;
   localparam int PD_N   = PP_W - 2;
   localparam int PD_L   = $clog2(PD_DIV);
   localparam int PD_SH  = PD_N + PD_L;
   localparam int PD_P_W = 2 * PD_N + 1;
   localparam int PD_Q_W = PD_N + 1 - PD_L;
   localparam logic [PD_N:0] PD_MUL = (PD_N + 1)'(((64'd1 << PD_SH)
      + 64'(PD_DIV) - 64'd1) / 64'(PD_DIV));

   typedef struct packed {
      logic signed [SENSE_W-1:0] sense;
      logic [VOLT_W-1:0]         volt;
   } sample_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF  = 2'd0,
      MODE_CAL  = 2'd1,
      MODE_MEAS = 2'd2
   } mode_type;

endpackage

### design/pma_cell.sv
// One cell of the sample window: holds one sense and one source sample.
// Depends on pma_pkg.
module pma_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  pma_pkg::sample_type sample_in,
   output pma_pkg::sample_type sample_out
);

   pma_pkg::sample_type sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift) begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

### design/pma_window.sv
// Sliding window built from a chain of pma_cell instances, with running sums.
// Depends on pma_pkg and pma_cell.
module pma_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift,
   input  pma_pkg::sample_type               sample,
   output logic signed [pma_pkg::SSUM_W-1:0] sense_sum,
   output logic [pma_pkg::VSUM_W-1:0]        volt_sum
);

   pma_pkg::sample_type tap [pma_pkg::WINDOW_LEN+1];

   logic signed [pma_pkg::SSUM_W-1:0] sense_sum_ff;
   logic signed [pma_pkg::SSUM_W-1:0] sense_sum_in;
   logic [pma_pkg::VSUM_W-1:0]        volt_sum_ff;
   logic [pma_pkg::VSUM_W-1:0]        volt_sum_in;

   assign tap[0] = sample;

   for (genvar i = 0; i < pma_pkg::WINDOW_LEN; i++) begin : g_cell
      pma_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .sample_in  (tap[i]),
         .sample_out (tap[i+1])
      );
   end

   assign sense_sum_in = sense_sum_ff + pma_pkg::SSUM_W'(sample.sense)
      - pma_pkg::SSUM_W'(tap[pma_pkg::WINDOW_LEN].sense);
   assign volt_sum_in = volt_sum_ff + pma_pkg::VSUM_W'(sample.volt)
      - pma_pkg::VSUM_W'(tap[pma_pkg::WINDOW_LEN].volt);

   always_ff @(posedge clock) begin
      if (reset) begin
         sense_sum_ff <= '0;
         volt_sum_ff  <= '0;
      end else if (shift) begin
         sense_sum_ff <= sense_sum_in;
         volt_sum_ff  <= volt_sum_in;
      end
   end

   assign sense_sum = sense_sum_ff;
   assign volt_sum  = volt_sum_ff;

endmodule

### design/power_meter_averager.sv
// Top level of the power meter averager: window, mode machine, offset and
// the pipelined constant divisions. Depends on pma_pkg and pma_window.
//
//  Channel  Ports                        Direction  Moves
//  req      req_valid/req_stall + fields in         one measurement request
//  rsp      rsp_valid/rsp_stall + fields out        one result per request
//  csr      csr_wr_en/csr_wr_data        in         hold threshold write
//
// One request is accepted every cycle unless a stalled result holds the pipeline.
// The nine pipeline stages are set by the reciprocal multiplications.
// Reset is synchronous and clears the window, sums, offset, mode and stage valid bits.
// A stalled result freezes the whole pipeline, and req_stall follows it.
module power_meter_averager (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [pma_pkg::HOLD_W-1:0]          csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [pma_pkg::SENSE_W-1:0]  req_sense_volt,
   input  logic [pma_pkg::VOLT_W-1:0]          req_source_volt,
   input  logic [pma_pkg::HOLD_W-1:0]          req_button_hold,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pma_pkg::MODE_W-1:0]          rsp_mode,
   output logic signed [pma_pkg::CORR_W-1:0]   rsp_cal_avg_sense,
   output logic signed [pma_pkg::CUR_W-1:0]    rsp_inst_current,
   output logic signed [pma_pkg::CUR_W-1:0]    rsp_mean_current,
   output logic [pma_pkg::OVOLT_W-1:0]         rsp_inst_volt,
   output logic [pma_pkg::OVOLT_W-1:0]         rsp_avg_volt,
   output logic signed [pma_pkg::PWR_W-1:0]    rsp_inst_power,
   output logic signed [pma_pkg::PWR_W-1:0]    rsp_mean_power
);

   logic                          en;
   logic                          accept;
   logic [pma_pkg::STAGES-1:0]    vld_ff;
   logic [pma_pkg::STAGES-1:0]    vld_in;
   logic [pma_pkg::HOLD_W-1:0]    thr_ff;

   pma_pkg::sample_type               sample;
   logic signed [pma_pkg::SSUM_W-1:0] sense_sum;
   logic [pma_pkg::VSUM_W-1:0]        volt_sum;

   // Stage 1
   logic signed [pma_pkg::SENSE_W-1:0] s1_sense_ff;
   logic [pma_pkg::VOLT_W-1:0]         s1_src_ff;
   logic [pma_pkg::HOLD_W-1:0]         s1_hold_ff;
   logic [pma_pkg::SSUM_W-1:0]         ss_mag;

   // Stage 2
   logic [pma_pkg::AS_P_W-1:0]         as_prod_ff;
   logic                               as_neg_ff;
   logic [pma_pkg::IV_P_W-1:0]         iv_prod_ff;
   logic [pma_pkg::AV_P_W-1:0]         av_prod_ff;
   logic signed [pma_pkg::SENSE_W-1:0] s2_sense_ff;
   logic [pma_pkg::HOLD_W-1:0]         s2_hold_ff;
   logic [pma_pkg::AS_Q_W-1:0]         as_q;
   logic [pma_pkg::IV_Q_W-1:0]         iv_q;
   logic [pma_pkg::AV_Q_W-1:0]         av_q;

   // Stage 3
   logic signed [pma_pkg::AS_Q_W-1:0]  s3_avg_sense_ff;
   logic signed [pma_pkg::SENSE_W-1:0] s3_sense_ff;
   logic [pma_pkg::HOLD_W-1:0]         s3_hold_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s3_inst_v_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s3_avg_v_ff;

   pma_pkg::mode_type                  mode_ff;
   pma_pkg::mode_type                  mode_in;
   logic signed [pma_pkg::SENSE_W-1:0] offset_ff;
   logic signed [pma_pkg::SENSE_W-1:0] offset_in;
   logic signed [pma_pkg::CORR_W-1:0]  avg_corr;
   logic signed [pma_pkg::CORR_W-1:0]  inst_corr;

   // Stage 4
   pma_pkg::mode_type                  s4_mode_ff;
   logic signed [pma_pkg::CORR_W-1:0]  s4_avg_corr_ff;
   logic signed [pma_pkg::CORR_W-1:0]  s4_inst_corr_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s4_inst_v_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s4_avg_v_ff;
   logic [pma_pkg::CD_N-1:0]           ic_mag;
   logic [pma_pkg::CD_N-1:0]           ac_mag;

   // Stage 5
   pma_pkg::mode_type                  s5_mode_ff;
   logic signed [pma_pkg::CORR_W-1:0]  s5_avg_corr_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s5_inst_v_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s5_avg_v_ff;
   logic [pma_pkg::CD_P_W-1:0]         ic_prod_ff;
   logic                               ic_neg_ff;
   logic [pma_pkg::CD_P_W-1:0]         ac_prod_ff;
   logic                               ac_neg_ff;
   logic [pma_pkg::CD_Q_W-1:0]         ic_q;
   logic [pma_pkg::CD_Q_W-1:0]         ac_q;

   // Stage 6
   pma_pkg::mode_type                  s6_mode_ff;
   logic signed [pma_pkg::CORR_W-1:0]  s6_avg_corr_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s6_inst_v_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s6_avg_v_ff;
   logic signed [pma_pkg::CUR_W-1:0]   s6_inst_cur_ff;
   logic signed [pma_pkg::CUR_W-1:0]   s6_avg_cur_ff;

   // Stage 7
   pma_pkg::mode_type                  s7_mode_ff;
   logic signed [pma_pkg::CORR_W-1:0]  s7_avg_corr_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s7_inst_v_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s7_avg_v_ff;
   logic signed [pma_pkg::CUR_W-1:0]   s7_inst_cur_ff;
   logic signed [pma_pkg::CUR_W-1:0]   s7_avg_cur_ff;
   logic signed [pma_pkg::PP_W-1:0]    ip_prod_ff;
   logic signed [pma_pkg::PP_W-1:0]    ap_prod_ff;
   logic [pma_pkg::PD_N-1:0]           ip_mag;
   logic [pma_pkg::PD_N-1:0]           ap_mag;

   // Stage 8
   pma_pkg::mode_type                  s8_mode_ff;
   logic signed [pma_pkg::CORR_W-1:0]  s8_avg_corr_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s8_inst_v_ff;
   logic [pma_pkg::OVOLT_W-1:0]        s8_avg_v_ff;
   logic signed [pma_pkg::CUR_W-1:0]   s8_inst_cur_ff;
   logic signed [pma_pkg::CUR_W-1:0]   s8_avg_cur_ff;
   logic [pma_pkg::PD_P_W-1:0]         ipd_prod_ff;
   logic                               ipd_neg_ff;
   logic [pma_pkg::PD_P_W-1:0]         apd_prod_ff;
   logic                               apd_neg_ff;
   logic [pma_pkg::PD_Q_W-1:0]         ipd_q;
   logic [pma_pkg::PD_Q_W-1:0]         apd_q;

   // Output stage
   pma_pkg::mode_type                  out_mode_ff;
   logic signed [pma_pkg::CORR_W-1:0]  out_avg_corr_ff;
   logic signed [pma_pkg::CUR_W-1:0]   out_inst_cur_ff;
   logic signed [pma_pkg::CUR_W-1:0]   out_avg_cur_ff;
   logic [pma_pkg::OVOLT_W-1:0]        out_inst_v_ff;
   logic [pma_pkg::OVOLT_W-1:0]        out_avg_v_ff;
   logic signed [pma_pkg::PWR_W-1:0]   out_inst_pwr_ff;
   logic signed [pma_pkg::PWR_W-1:0]   out_avg_pwr_ff;

   // Pipeline control.
   assign en        = !vld_ff[pma_pkg::STAGES-1] || !rsp_stall;
   assign req_stall = !en;
   assign accept    = req_valid && en;
   assign vld_in    = {vld_ff[pma_pkg::STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= pma_pkg::HOLD_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Sample window.
   assign sample.sense = req_sense_volt;
   assign sample.volt  = req_source_volt;

   pma_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift     (accept),
      .sample    (sample),
      .sense_sum (sense_sum),
      .volt_sum  (volt_sum)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sense_ff <= req_sense_volt;
         s1_src_ff   <= req_source_volt;
         s1_hold_ff  <= req_button_hold;
      end
   end

   // Stage 2: reciprocal products for the averages and the voltage.
   assign ss_mag = sense_sum[pma_pkg::SSUM_W-1] ? pma_pkg::SSUM_W'(-sense_sum)
                                                : pma_pkg::SSUM_W'(sense_sum);

   always_ff @(posedge clock) begin
      if (en) begin
         as_prod_ff  <= pma_pkg::AS_P_W'(ss_mag) * pma_pkg::AS_P_W'(pma_pkg::AS_MUL);
         as_neg_ff   <= sense_sum[pma_pkg::SSUM_W-1];
         iv_prod_ff  <= pma_pkg::IV_P_W'(s1_src_ff) * pma_pkg::IV_P_W'(pma_pkg::IV_MUL);
         av_prod_ff  <= pma_pkg::AV_P_W'(volt_sum) * pma_pkg::AV_P_W'(pma_pkg::AV_MUL);
         s2_sense_ff <= s1_sense_ff;
         s2_hold_ff  <= s1_hold_ff;
      end
   end

   // Stage 3: quotients, signed average and saturated voltages.
   assign as_q = as_prod_ff[pma_pkg::AS_P_W-1:pma_pkg::AS_SH];
   assign iv_q = iv_prod_ff[pma_pkg::IV_P_W-1:pma_pkg::IV_SH];
   assign av_q = av_prod_ff[pma_pkg::AV_P_W-1:pma_pkg::AV_SH];

   always_ff @(posedge clock) begin
      if (en) begin
         s3_avg_sense_ff <= as_neg_ff ? -as_q : as_q;
         s3_inst_v_ff    <= (iv_q[pma_pkg::IV_Q_W-1:pma_pkg::OVOLT_W] != '0) ? '1
                            : iv_q[pma_pkg::OVOLT_W-1:0];
         s3_avg_v_ff     <= (av_q[pma_pkg::AV_Q_W-1:pma_pkg::OVOLT_W] != '0) ? '1
                            : av_q[pma_pkg::OVOLT_W-1:0];
         s3_sense_ff     <= s2_sense_ff;
         s3_hold_ff      <= s2_hold_ff;
      end
   end

   // Stage 4: offset correction and the mode machine.
   assign avg_corr  = pma_pkg::CORR_W'(s3_avg_sense_ff) - pma_pkg::CORR_W'(offset_ff);
   assign inst_corr = pma_pkg::CORR_W'(s3_sense_ff) - pma_pkg::CORR_W'(offset_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= pma_pkg::MODE_OFF;
         offset_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      if (vld_ff[2] && en) begin
         case (mode_ff)
            pma_pkg::MODE_CAL: begin
               if (s3_hold_ff == '0) begin
                  offset_in = avg_corr[pma_pkg::SENSE_W-1:0];
                  mode_in   = pma_pkg::MODE_MEAS;
               end
            end
            pma_pkg::MODE_MEAS: begin
               if (s3_hold_ff >= thr_ff) begin
                  offset_in = '0;
                  mode_in   = pma_pkg::MODE_CAL;
               end
            end
            default: begin
               mode_in = pma_pkg::MODE_MEAS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_mode_ff      <= mode_in;
         s4_avg_corr_ff  <= avg_corr;
         s4_inst_corr_ff <= inst_corr;
         s4_inst_v_ff    <= s3_inst_v_ff;
         s4_avg_v_ff     <= s3_avg_v_ff;
      end
   end

   // Stage 5: current reciprocal products.
   assign ic_mag = s4_inst_corr_ff[pma_pkg::CORR_W-1] ? -s4_inst_corr_ff : s4_inst_corr_ff;
   assign ac_mag = s4_avg_corr_ff[pma_pkg::CORR_W-1] ? -s4_avg_corr_ff : s4_avg_corr_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ic_prod_ff     <= pma_pkg::CD_P_W'(ic_mag) * pma_pkg::CD_P_W'(pma_pkg::CD_MUL);
         ic_neg_ff      <= s4_inst_corr_ff[pma_pkg::CORR_W-1];
         ac_prod_ff     <= pma_pkg::CD_P_W'(ac_mag) * pma_pkg::CD_P_W'(pma_pkg::CD_MUL);
         ac_neg_ff      <= s4_avg_corr_ff[pma_pkg::CORR_W-1];
         s5_mode_ff     <= s4_mode_ff;
         s5_avg_corr_ff <= s4_avg_corr_ff;
         s5_inst_v_ff   <= s4_inst_v_ff;
         s5_avg_v_ff    <= s4_avg_v_ff;
      end
   end

   // Stage 6: signed currents.
   assign ic_q = ic_prod_ff[pma_pkg::CD_P_W-1:pma_pkg::CD_SH];
   assign ac_q = ac_prod_ff[pma_pkg::CD_P_W-1:pma_pkg::CD_SH];

   always_ff @(posedge clock) begin
      if (en) begin
         s6_inst_cur_ff <= ic_neg_ff ? -ic_q : ic_q;
         s6_avg_cur_ff  <= ac_neg_ff ? -ac_q : ac_q;
         s6_mode_ff     <= s5_mode_ff;
         s6_avg_corr_ff <= s5_avg_corr_ff;
         s6_inst_v_ff   <= s5_inst_v_ff;
         s6_avg_v_ff    <= s5_avg_v_ff;
      end
   end

   // Stage 7: current times voltage.
   always_ff @(posedge clock) begin
      if (en) begin
         ip_prod_ff     <= pma_pkg::PP_W'(s6_inst_cur_ff)
                           * pma_pkg::PP_W'($signed({1'b0, s6_inst_v_ff}));
         ap_prod_ff     <= pma_pkg::PP_W'(s6_avg_cur_ff)
                           * pma_pkg::PP_W'($signed({1'b0, s6_avg_v_ff}));
         s7_mode_ff     <= s6_mode_ff;
         s7_avg_corr_ff <= s6_avg_corr_ff;
         s7_inst_v_ff   <= s6_inst_v_ff;
         s7_avg_v_ff    <= s6_avg_v_ff;
         s7_inst_cur_ff <= s6_inst_cur_ff;
         s7_avg_cur_ff  <= s6_avg_cur_ff;
      end
   end

   // Stage 8: power reciprocal products.
   assign ip_mag = pma_pkg::PD_N'(ip_prod_ff[pma_pkg::PP_W-1] ? -ip_prod_ff : ip_prod_ff);
   assign ap_mag = pma_pkg::PD_N'(ap_prod_ff[pma_pkg::PP_W-1] ? -ap_prod_ff : ap_prod_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         ipd_prod_ff    <= pma_pkg::PD_P_W'(ip_mag) * pma_pkg::PD_P_W'(pma_pkg::PD_MUL);
         ipd_neg_ff     <= ip_prod_ff[pma_pkg::PP_W-1];
         apd_prod_ff    <= pma_pkg::PD_P_W'(ap_mag) * pma_pkg::PD_P_W'(pma_pkg::PD_MUL);
         apd_neg_ff     <= ap_prod_ff[pma_pkg::PP_W-1];
         s8_mode_ff     <= s7_mode_ff;
         s8_avg_corr_ff <= s7_avg_corr_ff;
         s8_inst_v_ff   <= s7_inst_v_ff;
         s8_avg_v_ff    <= s7_avg_v_ff;
         s8_inst_cur_ff <= s7_inst_cur_ff;
         s8_avg_cur_ff  <= s7_avg_cur_ff;
      end
   end

   // Output register.
   assign ipd_q = ipd_prod_ff[pma_pkg::PD_P_W-1:pma_pkg::PD_SH];
   assign apd_q = apd_prod_ff[pma_pkg::PD_P_W-1:pma_pkg::PD_SH];

   always_ff @(posedge clock) begin
      if (en) begin
         out_inst_pwr_ff <= ipd_neg_ff ? -ipd_q : ipd_q;
         out_avg_pwr_ff  <= apd_neg_ff ? -apd_q : apd_q;
         out_mode_ff     <= s8_mode_ff;
         out_avg_corr_ff <= s8_avg_corr_ff;
         out_inst_v_ff   <= s8_inst_v_ff;
         out_avg_v_ff    <= s8_avg_v_ff;
         out_inst_cur_ff <= s8_inst_cur_ff;
         out_avg_cur_ff  <= s8_avg_cur_ff;
      end
   end

   assign rsp_valid         = vld_ff[pma_pkg::STAGES-1];
   assign rsp_mode          = out_mode_ff;
   assign rsp_cal_avg_sense = out_avg_corr_ff;
   assign rsp_inst_current  = out_inst_cur_ff;
   assign rsp_mean_current  = out_avg_cur_ff;
   assign rsp_inst_volt     = out_inst_v_ff;
   assign rsp_avg_volt      = out_avg_v_ff;
   assign rsp_inst_power    = out_inst_pwr_ff;
   assign rsp_mean_power    = out_avg_pwr_ff;

   a_rsp_mode_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode != pma_pkg::MODE_OFF)
      else $error("A result reports the off mode.");

   a_cal_offset_clear: assert property (@(posedge clock) disable iff (reset)
      mode_ff == pma_pkg::MODE_CAL |-> offset_ff == '0)
      else $error("The offset is not clear during calibration.");

   a_offset_hold: assert property (@(posedge clock) disable iff (reset)
      !(vld_ff[2] && en) |=> $stable(offset_ff))
      else $error("The offset changed without a request leaving stage three.");

   a_current_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_inst_current <= 15'sd8389 && rsp_inst_current >= -15'sd8389))
      else $error("The instantaneous current is out of range.");

endmodule
